// ===== sv/spx_pkg.sv =====
// shared constants and polynomial coefficient tables for the sin(pi*x) evaluator
package spx_pkg;

    localparam int IN_FRAC_BITS_DEF  = 32;
    localparam int OUT_FRAC_BITS_DEF = 30;
    localparam int QF                = 36;
    localparam int HORNER_STEPS      = 6;
    localparam int COEF_W            = 41;

    // magnitude in units of 1e-12 to q36, rounded in two steps
    function automatic longint qp(input longint m);
        return (((m * 64'sd262144 + 64'sd500000) / 64'sd1000000) * 64'sd262144
                + 64'sd500000) / 64'sd1000000;
    endfunction

    localparam logic signed [COEF_W-1:0] SIN_COEF [0:6] = '{
        COEF_W'(qp(64'sd3141592653590)),
        COEF_W'(-qp(64'sd5167712780050)),
        COEF_W'(qp(64'sd2550164039874)),
        COEF_W'(-qp(64'sd599264528980)),
        COEF_W'(qp(64'sd82145870229)),
        COEF_W'(-qp(64'sd7370034513)),
        COEF_W'(qp(64'sd461593121))
    };

    localparam logic signed [COEF_W-1:0] COS_COEF [0:6] = '{
        COEF_W'(64'sd1 <<< QF),
        COEF_W'(-qp(64'sd4934802200545)),
        COEF_W'(qp(64'sd4058712126401)),
        COEF_W'(-qp(64'sd1335262767189)),
        COEF_W'(qp(64'sd235330550922)),
        COEF_W'(-qp(64'sd25804981837)),
        COEF_W'(qp(64'sd1907004404))
    };

endpackage

// ===== sv/sin_pi_x_eval_core.sv =====
// pipelined fixed-point sin(pi*x) evaluator with stream input and output
//
// s_tdata carries one argument x per item, signed, IN_FRAC_BITS fraction bits.
// m_tdata returns sin(pi*x), signed, OUT_FRAC_BITS fraction bits.
// every accepted item gives exactly one result, in order.
// throughput: one item per cycle while m_tready stays high.
// the path runs through 20 register stages: six horner steps of two stages
// each (split multiply, then coefficient add), plus front end, folding, two
// squaring stages, two final multiply stages, rounding and sign stages.
// the wide products are cut into two partial products per stage pair.
// each stage holds its own valid bit; on a stall of m_tready the
// results hold, empty stages still fill, and s_tready falls only once
// every stage is occupied.
// aresetn (synchronous, active low) empties the pipeline; no item in
// flight survives it and no clearing pass follows.
module sin_pi_x_eval_core #(
    parameter int IN_FRAC_BITS  = spx_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = spx_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sine_value
);

    localparam int HS       = spx_pkg::HORNER_STEPS;
    localparam int ST_FRONT = 0;
    localparam int ST_PATH  = 1;
    localparam int ST_SQP   = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_HORN  = 4;
    localparam int ST_FMUL  = ST_HORN + 2 * HS;
    localparam int ST_FRES  = ST_FMUL + 1;
    localparam int ST_RND   = ST_FRES + 1;
    localparam int ST_OUT   = ST_RND + 1;
    localparam int NST      = ST_OUT + 1;

    localparam int UP = (IN_FRAC_BITS <= spx_pkg::QF) ? spx_pkg::QF - IN_FRAC_BITS : 0;
    localparam int XW = 64 + UP;
    localparam int RS = (OUT_FRAC_BITS < spx_pkg::QF) ? spx_pkg::QF - OUT_FRAC_BITS : 0;
    localparam int LS = (OUT_FRAC_BITS >= spx_pkg::QF) ? OUT_FRAC_BITS - spx_pkg::QF : 0;
    localparam logic [63:0] HALF = (64'd1 << RS) >> 1;
    localparam logic [63:0] LIM  = 64'd1 << OUT_FRAC_BITS;

    localparam logic [36:0] Q_ONE  = 37'd1 << spx_pkg::QF;
    localparam logic [36:0] Q_HALF = Q_ONE >> 1;
    localparam logic [36:0] Q_QTR  = Q_ONE >> 2;
    localparam logic [36:0] Q_3QTR = Q_HALF + Q_QTR;
    localparam logic [32:0] T_MAX  = 33'd1 << 32;

    typedef struct packed {
        logic        xs;
        logic        cosp;
        logic        an;
        logic [35:0] f;
        logic [34:0] a_mag;
        logic [36:0] m;
        logic [32:0] t;
        logic [56:0] pl;
        logic [56:0] ph;
        logic [39:0] am;
        logic [31:0] y;
    } stage_t;

    stage_t           st_reg  [NST];
    stage_t           st_next [NST];
    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   v_next;
    logic [NST-1:0]   ready;

    logic [63:0]      x_abs;
    logic [62:0]      x_mag;
    logic [XW-1:0]    x_wide;
    logic [36:0]      f37;
    logic [77:0]      sq_sum;
    logic signed [40:0] c_init;
    logic             h_an   [HS];
    logic [39:0]      h_am   [HS];
    logic [77:0]      h_sum  [HS];
    logic signed [40:0] h_prod [HS];
    logic signed [40:0] h_c    [HS];
    logic signed [40:0] h_pos  [HS];
    logic signed [40:0] h_neg  [HS];
    logic [77:0]      f_sum;
    logic [63:0]      r_rnd;

    // a stage may load when some stage at or after it is free or the output moves
    always_comb begin
        for (int i = 0; i < NST; i++) begin
            ready[i] = m_tready || !(&(v_reg | NST'((NST'(1) << i) - NST'(1))));
        end
    end

    always_comb begin
        v_next[0] = ready[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < NST; i++) begin
            v_next[i] = ready[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign s_tready = ready[ST_FRONT];
    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = st_reg[ST_OUT].y;

    always_comb begin
        for (int i = 1; i < NST; i++) begin
            st_next[i] = st_reg[i-1];
        end

        // magnitude, saturation and split
        x_abs  = s_tdata[63] ? -s_tdata : s_tdata;
        x_mag  = x_abs[63] ? '1 : x_abs[62:0];
        x_wide = XW'(x_mag) << UP;
        st_next[ST_FRONT]    = '0;
        st_next[ST_FRONT].xs = s_tdata[63] ^ x_mag[IN_FRAC_BITS];
        st_next[ST_FRONT].f  = x_wide[IN_FRAC_BITS+UP-1 -: 36];

        // fold onto the sine or cosine range
        f37 = {1'b0, st_reg[ST_FRONT].f};
        st_next[ST_PATH].cosp = (f37 >= Q_QTR) && (f37 <= Q_3QTR);
        if (st_next[ST_PATH].cosp) begin
            st_next[ST_PATH].a_mag = (f37 <= Q_HALF) ? 35'(Q_HALF - f37) : 35'(f37 - Q_HALF);
            st_next[ST_PATH].m     = Q_ONE;
        end else begin
            st_next[ST_PATH].a_mag = (f37 > Q_3QTR) ? 35'(Q_ONE - f37) : 35'(f37);
            st_next[ST_PATH].m     = {2'b00, st_next[ST_PATH].a_mag};
        end

        // square in two partial products
        st_next[ST_SQP].pl = 57'(53'(st_reg[ST_PATH].a_mag) * 53'(st_reg[ST_PATH].a_mag[17:0]));
        st_next[ST_SQP].ph = 57'(52'(st_reg[ST_PATH].a_mag) * 52'(st_reg[ST_PATH].a_mag[34:18]));

        sq_sum = 78'(st_reg[ST_SQP].pl) + (78'(st_reg[ST_SQP].ph) << 18);
        st_next[ST_SQ].t = sq_sum[68:36];

        // horner steps, multiply stage then add stage
        c_init = st_reg[ST_SQ].cosp ? spx_pkg::COS_COEF[6] : spx_pkg::SIN_COEF[6];
        for (int k = 0; k < HS; k++) begin
            if (k == 0) begin
                h_an[k] = c_init[40];
                h_am[k] = c_init[40] ? 40'(-c_init) : 40'(c_init);
            end else begin
                h_an[k] = st_reg[ST_HORN+2*k-1].an;
                h_am[k] = st_reg[ST_HORN+2*k-1].am;
            end
            st_next[ST_HORN+2*k].an = h_an[k];
            st_next[ST_HORN+2*k].pl =
                57'(53'(st_reg[ST_HORN+2*k-1].t) * 53'(h_am[k][19:0]));
            st_next[ST_HORN+2*k].ph =
                57'(53'(st_reg[ST_HORN+2*k-1].t) * 53'(h_am[k][39:20]));

            h_sum[k]  = 78'(st_reg[ST_HORN+2*k].pl) + (78'(st_reg[ST_HORN+2*k].ph) << 20);
            h_prod[k] = $signed(h_sum[k][76:36]);
            h_c[k]    = st_reg[ST_HORN+2*k].cosp ? spx_pkg::COS_COEF[HS-1-k]
                                                 : spx_pkg::SIN_COEF[HS-1-k];
            if (st_reg[ST_HORN+2*k].an) begin
                h_pos[k] = h_c[k] - h_prod[k];
                h_neg[k] = h_prod[k] - h_c[k];
            end else begin
                h_pos[k] = h_c[k] + h_prod[k];
                h_neg[k] = -h_c[k] - h_prod[k];
            end
            st_next[ST_HORN+2*k+1].an = h_pos[k][40];
            st_next[ST_HORN+2*k+1].am = h_pos[k][40] ? h_neg[k][39:0] : h_pos[k][39:0];
        end

        // odd sine path times a, cosine path times one
        st_next[ST_FMUL].pl = 57'(st_reg[ST_FMUL-1].m) * 57'(st_reg[ST_FMUL-1].am[19:0]);
        st_next[ST_FMUL].ph = 57'(st_reg[ST_FMUL-1].m) * 57'(st_reg[ST_FMUL-1].am[39:20]);

        f_sum = 78'(st_reg[ST_FMUL].pl) + (78'(st_reg[ST_FMUL].ph) << 20);
        st_next[ST_FRES].am = f_sum[75:36];
        st_next[ST_FRES].an = (st_reg[ST_FMUL].an && (f_sum[75:36] != 40'd0))
                              ^ st_reg[ST_FMUL].xs;

        // round to nearest and clamp at one
        r_rnd = ((64'(st_reg[ST_FRES].am) + HALF) >> RS) << LS;
        if (r_rnd > LIM) begin
            r_rnd = LIM;
        end
        st_next[ST_RND].y = r_rnd[31:0];

        st_next[ST_OUT].y = st_reg[ST_RND].an ? -st_reg[ST_RND].y : st_reg[ST_RND].y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NST; i++) begin
            if (ready[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // items in flight change only by what enters and leaves
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> $countones(v_reg) == $past($countones(v_reg))
                 + $past(int'(s_tvalid && s_tready)) - $past(int'(m_tvalid && m_tready)))
        else $error("item count in pipeline inconsistent");

    // folded argument squared never exceeds one sixteenth
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_SQ] |-> st_reg[ST_SQ].t <= T_MAX)
        else $error("squared argument out of range");

    // horner result keeps headroom in the accumulator width
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_FMUL-1] |-> !st_reg[ST_FMUL-1].am[39])
        else $error("horner accumulator overflow");

endmodule

// ===== bench/sin_pi_x_checker.sv =====
// stream monitor that predicts sin(pi*x) for each accepted argument and checks the results
module sin_pi_x_checker #(
    parameter int IN_FRAC_BITS  = spx_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = spx_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // x_value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // sine_value
    output int          fail_count,
    output int          waiting
);

    localparam int FB = spx_pkg::QF;

    typedef struct {
        logic [63:0] arg;
        logic [31:0] sine;
    } sine_entry_t;

    sine_entry_t pending_sines[$];
    longint sine_poly [0:6];
    longint cosine_poly [0:6];

    // coefficient in units of 1e-12 to q36, rounded in two steps of 2^18
    function automatic longint pico_to_q36(input longint pico);
        longint step;
        step = (pico * 262144 + 500000) / 1000000;
        return (step * 262144 + 500000) / 1000000;
    endfunction

    // q36 product, truncated toward zero
    function automatic longint q36_mul(input longint a, input longint b);
        logic          neg;
        logic [63:0]   ua;
        logic [63:0]   ub;
        logic [127:0]  prod;
        logic [63:0]   mag;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        mag  = {1'b0, prod[FB+62:FB]};
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint eval_poly(input bit use_cos, input longint t);
        longint acc;
        acc = use_cos ? cosine_poly[6] : sine_poly[6];
        for (int i = 5; i >= 0; i--) begin
            acc = (use_cos ? cosine_poly[i] : sine_poly[i]) + q36_mul(t, acc);
        end
        return acc;
    endfunction

    function automatic logic [31:0] predict_sine(input logic [63:0] raw);
        logic        neg_x;
        logic        odd;
        logic        neg_r;
        logic [63:0] mag;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] f36;
        logic [63:0] rmag;
        logic [63:0] lim;
        longint      f;
        longint      a;
        longint      t;
        longint      res;
        longint      quarter;
        int          up;
        int          dn;
        int          s;
        neg_x = raw[63];
        mag   = neg_x ? 64'(-raw) : raw;
        // most negative argument saturates
        if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        whole = mag >> IN_FRAC_BITS;
        frac  = mag & ((64'd1 << IN_FRAC_BITS) - 64'd1);
        odd   = whole[0];
        up    = (IN_FRAC_BITS <= FB) ? FB - IN_FRAC_BITS : 0;
        dn    = (IN_FRAC_BITS > FB) ? IN_FRAC_BITS - FB : 0;
        f36   = (frac << up) >> dn;
        f     = longint'(f36);
        quarter = longint'(64'd1 << (FB - 2));
        if (f >= quarter && f <= 3 * quarter) begin
            a   = longint'(64'd1 << (FB - 1)) - f;
            t   = q36_mul(a, a);
            res = eval_poly(1'b1, t);
        end else begin
            a   = (f > 3 * quarter) ? longint'(64'd1 << FB) - f : f;
            t   = q36_mul(a, a);
            res = q36_mul(a, eval_poly(1'b0, t));
        end
        neg_r = (res < 0) != (neg_x != odd);
        rmag  = (res < 0) ? 64'(-res) : 64'(res);
        if (OUT_FRAC_BITS < FB) begin
            s    = FB - OUT_FRAC_BITS;
            rmag = (rmag + (64'd1 << (s - 1))) >> s;
        end else begin
            rmag = rmag << (OUT_FRAC_BITS - FB);
        end
        lim = 64'd1 << OUT_FRAC_BITS;
        if (rmag > lim) begin
            rmag = lim;
        end
        return neg_r ? 32'(-rmag) : rmag[31:0];
    endfunction

    initial begin
        sine_poly[0]   =  pico_to_q36(64'sd3141592653590);
        sine_poly[1]   = -pico_to_q36(64'sd5167712780050);
        sine_poly[2]   =  pico_to_q36(64'sd2550164039874);
        sine_poly[3]   = -pico_to_q36(64'sd599264528980);
        sine_poly[4]   =  pico_to_q36(64'sd82145870229);
        sine_poly[5]   = -pico_to_q36(64'sd7370034513);
        sine_poly[6]   =  pico_to_q36(64'sd461593121);
        cosine_poly[0] =  longint'(64'd1 << FB);
        cosine_poly[1] = -pico_to_q36(64'sd4934802200545);
        cosine_poly[2] =  pico_to_q36(64'sd4058712126401);
        cosine_poly[3] = -pico_to_q36(64'sd1335262767189);
        cosine_poly[4] =  pico_to_q36(64'sd235330550922);
        cosine_poly[5] = -pico_to_q36(64'sd25804981837);
        cosine_poly[6] =  pico_to_q36(64'sd1907004404);
        fail_count = 0;
        waiting    = 0;
    end

    always @(posedge aclk) begin
        sine_entry_t entry;
        sine_entry_t oldest;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                entry.arg  = s_tdata;
                entry.sine = predict_sine(s_tdata);
                pending_sines.push_back(entry);
            end
            if (m_tvalid && m_tready) begin
                if (pending_sines.size() == 0) begin
                    $display("%0t: unexpected sine item, expected none, got %h",
                             $realtime, m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    oldest = pending_sines.pop_front();
                    if (m_tdata !== oldest.sine) begin
                        $display("%0t: sine mismatch for x=%h, expected %h, got %h",
                                 $realtime, oldest.arg, oldest.sine, m_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        waiting = pending_sines.size();
    end

endmodule

// ===== bench/testbench.sv =====
// top of the sin(pi*x) evaluator bench: clock, reset, argument stream, result back-pressure, verdict
module testbench;

    localparam int ITEM_TOTAL  = 1400;
    localparam int QUIET_AFTER = 1250;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // x_value
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // sine_value

    int fail_count;
    int waiting;
    int sent_count;
    bit winding_down;
    bit hold_done;
    int idle_cycles;

    sin_pi_x_eval_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sin_pi_x_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // arguments of several shapes: raw bits, small whole parts, fractions near the branch points
    function automatic logic [63:0] random_arg();
        logic [63:0] whole;
        logic [63:0] base;
        logic [63:0] x;
        int          off;
        case ($urandom_range(0, 3))
            0: x = {$urandom, $urandom};
            1: begin
                whole = 64'($urandom_range(0, 15));
                x = (whole << 32) | 64'($urandom);
            end
            2: begin
                whole = 64'($urandom_range(0, 7));
                case ($urandom_range(0, 4))
                    0: base = 64'd0;
                    1: base = 64'd1 << 30;
                    2: base = 64'd2 << 30;
                    3: base = 64'd3 << 30;
                    default: base = 64'd1 << 32;
                endcase
                off = int'($urandom_range(0, 128)) - 64;
                x = (whole << 32) + base + 64'(longint'(off));
            end
            default: x = {1'b0, 31'($urandom), $urandom};
        endcase
        if ($urandom_range(0, 1) == 1) begin
            x = 64'(-x);
        end
        return x;
    endfunction

    task automatic send_arg(input logic [63:0] x);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count = sent_count + 1;
        if (sent_count >= QUIET_AFTER) begin
            winding_down = 1'b1;
        end
        if (!winding_down && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // receiver back-pressure, with one long hold-off to fill the pipeline
    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!winding_down && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] directed_args [$];
        sent_count   = 0;
        winding_down = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 64'd0;
        directed_args = '{
            64'h0000_0000_0000_0000,   // zero
            64'h8000_0000_0000_0000,   // most negative, saturates
            64'h7FFF_FFFF_FFFF_FFFF,   // most positive
            64'hFFFF_FFFF_FFFF_FFFF,   // smallest negative step
            64'h0000_0000_0000_0001,   // smallest positive step
            64'h0000_0000_3FFF_FFFF,   // just below a quarter
            64'h0000_0000_4000_0000,   // a quarter, cosine side
            64'h0000_0000_8000_0000,   // one half, peak
            64'hFFFF_FFFF_8000_0000,   // minus one half
            64'h0000_0000_C000_0000,   // three quarters, cosine side
            64'h0000_0000_C000_0001,   // just above three quarters
            64'h0000_0000_FFFF_FFFF,   // fraction all ones
            64'h0000_0001_0000_0000,   // one
            64'h0000_0001_8000_0000,   // one and a half, odd whole part
            64'hFFFF_FFFE_8000_0000,   // minus one and a half
            64'h0000_0003_4000_0000,   // odd whole part, quarter
            64'h0000_0002_2000_0000,   // even whole part, small fraction
            64'h7FFF_FFFF_8000_0000,   // largest whole part, half
            64'h8000_0000_8000_0000,   // large negative, half
            64'h5555_5555_AAAA_AAAA,   // alternating bits
            64'hAAAA_AAAA_5555_5555
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_args[i]) begin
            send_arg(directed_args[i]);
        end
        while (sent_count < ITEM_TOTAL) begin
            send_arg(random_arg());
        end
        s_tvalid <= 1'b0;
        while (waiting != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && waiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
